// File: hdl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared widths, stage counts and helpers of the primary ray direction pipe.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int CoordBits   = 12;
  localparam int NdcFrac     = 16;
  localparam int QuotBits    = CoordBits + NdcFrac + 1;      // pixel * 2^17 / size
  localparam int NdcBits     = QuotBits + 1;                 // signed NDC, Q.16
  localparam int NdcPerStage = 4;
  localparam int NdcStages   = (QuotBits + NdcPerStage - 1) / NdcPerStage;

  localparam int CoefBits    = 16;
  localparam int CoefFrac    = CoefBits - 4;
  localparam int RegBits     = 3 * CoefBits;
  localparam int VpBits      = 2 * CoordBits;
  localparam int ProdBits    = CoefBits + NdcBits;
  localparam int TBits       = 48;
  localparam int PosBits     = 6;

  localparam int NormBits    = 30;                           // max magnitude in [2^29, 2^30)
  localparam int SqBits      = 2 * NormBits + 2;
  localparam int RootBits    = SqBits / 2;
  localparam int SqPerStage  = 2;
  localparam int SqStages    = (RootBits + SqPerStage - 1) / SqPerStage;

  localparam int DirFrac     = 14;
  localparam int QBits       = DirFrac + 1;
  localparam int DivPerStage = 2;
  localparam int DivStages   = (QBits + DivPerStage - 1) / DivPerStage;
  localparam int DirBits     = 16;
  localparam int MulBits     = CoefBits + DirBits;
  localparam int AccBits     = MulBits + 1;

  // ndc divider, square root, divider, fixed arithmetic and output stages
  localparam int Latency     = NdcStages + SqStages + DivStages + 12;
  localparam int SideDepth   = SqStages + DivStages + 8;
  localparam int NormDepth   = SqStages + 3;

  typedef enum logic [2:0] {
    REG_VIEWPORT = 3'd0,
    REG_PROJ_X   = 3'd1,
    REG_PROJ_Y   = 3'd2,
    REG_PROJ_Z   = 3'd3,
    REG_PROJ_W   = 3'd4,
    REG_VIEW_X   = 3'd5,
    REG_VIEW_Y   = 3'd6,
    REG_VIEW_Z   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
  } side_t;

  function automatic logic signed [CoefBits-1:0] coef(input logic [RegBits-1:0] r,
                                                     input int unsigned k);
    return r[k*CoefBits +: CoefBits];
  endfunction

endpackage

// File: hdl/prd_ndc.sv
// ----------------------------------------------------------------------------
// prd_ndc
// Pipelined restoring divider: ndc = floor(pixel * 2^17 / size) - 2^16.
// ----------------------------------------------------------------------------
module prd_ndc (
  input  logic                                clk_i,
  input  logic [prd_pkg::CoordBits-1:0]       pix_i,
  input  logic [prd_pkg::CoordBits-1:0]       size_i,
  output logic signed [prd_pkg::NdcBits-1:0]  ndc_o
);

  logic [prd_pkg::CoordBits-1:0] rem_in [prd_pkg::NdcStages];
  logic [prd_pkg::QuotBits-1:0]  nq_in  [prd_pkg::NdcStages];
  logic [prd_pkg::CoordBits-1:0] rem_d  [prd_pkg::NdcStages];
  logic [prd_pkg::QuotBits-1:0]  nq_d   [prd_pkg::NdcStages];
  logic [prd_pkg::CoordBits-1:0] rem_q  [prd_pkg::NdcStages];
  logic [prd_pkg::QuotBits-1:0]  nq_q   [prd_pkg::NdcStages];

  for (genvar s = 0; s < prd_pkg::NdcStages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s] = '0;
      assign nq_in[s]  = {pix_i, {(prd_pkg::NdcFrac + 1){1'b0}}};
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign nq_in[s]  = nq_q[s-1];
    end

    // dividend bits shift out of the top while quotient bits fill the bottom
    always_comb begin
      logic [prd_pkg::CoordBits:0]   r;
      logic [prd_pkg::CoordBits-1:0] rem;
      logic [prd_pkg::QuotBits-1:0]  nq;
      rem = rem_in[s];
      nq  = nq_in[s];
      r   = '0;
      for (int j = 0; j < prd_pkg::NdcPerStage; j++) begin
        if (s * prd_pkg::NdcPerStage + j < prd_pkg::QuotBits) begin
          r  = {rem, nq[prd_pkg::QuotBits-1]};
          nq = {nq[prd_pkg::QuotBits-2:0], 1'b0};
          if (r >= {1'b0, size_i}) begin
            r     = r - {1'b0, size_i};
            nq[0] = 1'b1;
          end
          rem = r[prd_pkg::CoordBits-1:0];
        end
      end
      rem_d[s] = rem;
      nq_d[s]  = nq;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d[s];
      nq_q[s]  <= nq_d[s];
    end
  end

  assign ndc_o = signed'({1'b0, nq_q[prd_pkg::NdcStages-1]}
                         - prd_pkg::NdcBits'(1 << prd_pkg::NdcFrac));

endmodule

// File: hdl/prd_isqrt.sv
// ----------------------------------------------------------------------------
// prd_isqrt
// Pipelined digit-by-digit integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
module prd_isqrt (
  input  logic                          clk_i,
  input  logic [prd_pkg::SqBits-1:0]    rad_i,
  output logic [prd_pkg::RootBits-1:0]  root_o
);

  localparam int RemBits = prd_pkg::RootBits + 2;

  logic [RemBits-1:0]           rem_in  [prd_pkg::SqStages];
  logic [prd_pkg::RootBits-1:0] root_in [prd_pkg::SqStages];
  logic [prd_pkg::SqBits-1:0]   rad_in  [prd_pkg::SqStages];
  logic [RemBits-1:0]           rem_d   [prd_pkg::SqStages];
  logic [prd_pkg::RootBits-1:0] root_d  [prd_pkg::SqStages];
  logic [prd_pkg::SqBits-1:0]   rad_d   [prd_pkg::SqStages];
  logic [RemBits-1:0]           rem_q   [prd_pkg::SqStages];
  logic [prd_pkg::RootBits-1:0] root_q  [prd_pkg::SqStages];
  logic [prd_pkg::SqBits-1:0]   rad_q   [prd_pkg::SqStages];

  for (genvar s = 0; s < prd_pkg::SqStages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s]  = '0;
      assign root_in[s] = '0;
      assign rad_in[s]  = rad_i;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign root_in[s] = root_q[s-1];
      assign rad_in[s]  = rad_q[s-1];
    end

    always_comb begin
      logic [RemBits+1:0]           r;
      logic [RemBits+1:0]           trial;
      logic [RemBits-1:0]           rem;
      logic [prd_pkg::RootBits-1:0] root;
      logic [prd_pkg::SqBits-1:0]   rad;
      rem   = rem_in[s];
      root  = root_in[s];
      rad   = rad_in[s];
      r     = '0;
      trial = '0;
      for (int j = 0; j < prd_pkg::SqPerStage; j++) begin
        if (s * prd_pkg::SqPerStage + j < prd_pkg::RootBits) begin
          r     = {rem, rad[prd_pkg::SqBits-1 -: 2]};
          rad   = {rad[prd_pkg::SqBits-3:0], 2'b00};
          trial = {2'b00, root, 2'b01};
          if (r >= trial) begin
            r    = r - trial;
            root = {root[prd_pkg::RootBits-2:0], 1'b1};
          end else begin
            root = {root[prd_pkg::RootBits-2:0], 1'b0};
          end
          rem = r[RemBits-1:0];
        end
      end
      rem_d[s]  = rem;
      root_d[s] = root;
      rad_d[s]  = rad;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d[s];
      root_q[s] <= root_d[s];
      rad_q[s]  <= rad_d[s];
    end
  end

  assign root_o = root_q[prd_pkg::SqStages-1];

endmodule

// File: hdl/pixel_ray_direction.sv
// ----------------------------------------------------------------------------
// pixel_ray_direction
// Pinhole camera primary ray: pixel -> NDC -> inverse projection -> normalize
// -> inverse view rotation, all fixed point.
//
//   channel   signals                                      direction
//   request   start_i, busy_o, pixel_x_i, pixel_y_i        in
//   config    cfg_we_i, cfg_idx_i, cfg_data_i              in
//   result    result_valid_o, dir_x/y/z_o, degenerate_o    out
//
// Fully pipelined: one request per cycle. Stages: NDC divider 8, square root 16,
// normalize divider 8, arithmetic stages 12.
// busy_o stays low; the result strobe lasts one cycle and cannot be held off.
// Reset clears the valid chain and the registers; the datapath is not reset.
// ----------------------------------------------------------------------------
module pixel_ray_direction (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [prd_pkg::CoordBits-1:0]       pixel_x_i,
  input  logic [prd_pkg::CoordBits-1:0]       pixel_y_i,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [prd_pkg::RegBits-1:0]         cfg_data_i,
  output logic                                result_valid_o,
  output logic signed [prd_pkg::DirBits-1:0]  dir_x_o,
  output logic signed [prd_pkg::DirBits-1:0]  dir_y_o,
  output logic signed [prd_pkg::DirBits-1:0]  dir_z_o,
  output logic                                degenerate_o
);

  localparam int TB = prd_pkg::TBits;
  localparam int NB = prd_pkg::NormBits;
  localparam int RB = prd_pkg::RootBits;
  localparam int QB = prd_pkg::QBits;

  // ---------------- configuration ----------------
  logic [prd_pkg::VpBits-1:0]  viewport_q;
  logic [prd_pkg::RegBits-1:0] proj_q [4];
  logic [prd_pkg::RegBits-1:0] view_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewport_q <= '0;
      for (int i = 0; i < 4; i++) proj_q[i] <= '0;
      for (int i = 0; i < 3; i++) view_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (prd_pkg::reg_idx_e'(cfg_idx_i))
        prd_pkg::REG_VIEWPORT: viewport_q <= cfg_data_i[prd_pkg::VpBits-1:0];
        prd_pkg::REG_PROJ_X:   proj_q[0]  <= cfg_data_i;
        prd_pkg::REG_PROJ_Y:   proj_q[1]  <= cfg_data_i;
        prd_pkg::REG_PROJ_Z:   proj_q[2]  <= cfg_data_i;
        prd_pkg::REG_PROJ_W:   proj_q[3]  <= cfg_data_i;
        prd_pkg::REG_VIEW_X:   view_q[0]  <= cfg_data_i;
        prd_pkg::REG_VIEW_Y:   view_q[1]  <= cfg_data_i;
        prd_pkg::REG_VIEW_Z:   view_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [prd_pkg::CoordBits-1:0] width, height;
  assign width  = viewport_q[prd_pkg::CoordBits-1:0];
  assign height = viewport_q[prd_pkg::VpBits-1:prd_pkg::CoordBits];

  // ---------------- valid chain ----------------
  logic                        accept;
  logic [prd_pkg::Latency-1:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[prd_pkg::Latency-2:0], accept};
  end

  // ---------------- NDC ----------------
  logic signed [prd_pkg::NdcBits-1:0] ndc_x, ndc_y;

  prd_ndc u_ndc_x (.clk_i, .pix_i(pixel_x_i), .size_i(width),  .ndc_o(ndc_x));
  prd_ndc u_ndc_y (.clk_i, .pix_i(pixel_y_i), .size_i(height), .ndc_o(ndc_y));

  // ---------------- projection rows ----------------
  logic signed [prd_pkg::ProdBits-1:0] pa_q [4];
  logic signed [prd_pkg::ProdBits-1:0] pb_q [4];
  logic signed [TB-1:0]                t_q  [4];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      pa_q[r] <= prd_pkg::coef(proj_q[r], 0) * ndc_x;
      pb_q[r] <= prd_pkg::coef(proj_q[r], 1) * ndc_y;
      t_q[r]  <= TB'(pa_q[r]) + TB'(pb_q[r])
                 + (TB'(prd_pkg::coef(proj_q[r], 2)) <<< prd_pkg::NdcFrac);
    end
  end

  // ---------------- magnitudes, leading one, scaling ----------------
  logic [TB-1:0]               mag_q  [3];
  logic [TB-1:0]               mag4_q [3];
  logic [2:0]                  neg3_q;
  logic                        wz3_q;
  logic [prd_pkg::PosBits-1:0] pos_q;
  prd_pkg::side_t              side_q [prd_pkg::SideDepth];
  logic [NB-1:0]               nrm_q  [prd_pkg::NormDepth][3];
  logic [prd_pkg::PosBits-1:0] pos_d;
  logic                        mz_d;
  logic [TB-1:0]               mor;

  always_comb begin
    mor   = mag_q[0] | mag_q[1] | mag_q[2];
    mz_d  = (mor == '0);
    pos_d = '0;
    for (int i = 0; i < TB; i++) begin
      if (mor[i]) pos_d = prd_pkg::PosBits'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      mag_q[k]  <= t_q[k][TB-1] ? TB'(-t_q[k]) : TB'(t_q[k]);
      neg3_q[k] <= t_q[k][TB-1] ^ t_q[3][TB-1];
      mag4_q[k] <= mag_q[k];
    end
    wz3_q         <= (t_q[3] == '0);
    pos_q         <= pos_d;
    side_q[0].neg <= neg3_q;
    side_q[0].deg <= wz3_q | mz_d;
    for (int i = 1; i < prd_pkg::SideDepth; i++) side_q[i] <= side_q[i-1];
    // largest magnitude lands in [2^29, 2^30); right shifts truncate
    for (int k = 0; k < 3; k++) begin
      if (pos_q >= prd_pkg::PosBits'(NB - 1))
        nrm_q[0][k] <= NB'(mag4_q[k] >> (pos_q - prd_pkg::PosBits'(NB - 1)));
      else
        nrm_q[0][k] <= NB'(mag4_q[k] << (prd_pkg::PosBits'(NB - 1) - pos_q));
    end
    for (int i = 1; i < prd_pkg::NormDepth; i++) nrm_q[i] <= nrm_q[i-1];
  end

  // ---------------- length ----------------
  logic [2*NB-1:0]            sq_q [3];
  logic [prd_pkg::SqBits-1:0] sum_q;
  logic [RB-1:0]              len;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) sq_q[k] <= nrm_q[0][k] * nrm_q[0][k];
    sum_q <= prd_pkg::SqBits'(sq_q[0]) + prd_pkg::SqBits'(sq_q[1])
             + prd_pkg::SqBits'(sq_q[2]);
  end

  prd_isqrt u_isqrt (.clk_i, .rad_i(sum_q), .root_o(len));

  // ---------------- normalize divider ----------------
  localparam int DvdBits = NB + prd_pkg::DirFrac + 1;

  logic [RB-1:0] dv_rem_in [prd_pkg::DivStages][3];
  logic [QB-1:0] dv_nq_in  [prd_pkg::DivStages][3];
  logic [RB-1:0] dv_len_in [prd_pkg::DivStages];
  logic [RB-1:0] dv_rem_d  [prd_pkg::DivStages][3];
  logic [QB-1:0] dv_nq_d   [prd_pkg::DivStages][3];
  logic [RB-1:0] dv_rem_q  [prd_pkg::DivStages][3];
  logic [QB-1:0] dv_nq_q   [prd_pkg::DivStages][3];
  logic [RB-1:0] dv_len_q  [prd_pkg::DivStages];
  logic [RB-1:0] d0_rem_q  [3];
  logic [QB-1:0] d0_nq_q   [3];
  logic [RB-1:0] d0_len_q;

  always_ff @(posedge clk_i) begin
    logic [DvdBits-1:0] dvd;
    for (int k = 0; k < 3; k++) begin
      dvd = {1'b0, nrm_q[prd_pkg::NormDepth-1][k], {prd_pkg::DirFrac{1'b0}}}
            + DvdBits'(len >> 1);
      // quotient fits QB bits, so the upper part is already below len
      d0_rem_q[k] <= RB'(dvd[DvdBits-1:QB]);
      d0_nq_q[k]  <= dvd[QB-1:0];
    end
    d0_len_q <= len;
  end

  for (genvar s = 0; s < prd_pkg::DivStages; s++) begin : g_div
    if (s == 0) begin : g_first
      assign dv_rem_in[s] = d0_rem_q;
      assign dv_nq_in[s]  = d0_nq_q;
      assign dv_len_in[s] = d0_len_q;
    end else begin : g_next
      assign dv_rem_in[s] = dv_rem_q[s-1];
      assign dv_nq_in[s]  = dv_nq_q[s-1];
      assign dv_len_in[s] = dv_len_q[s-1];
    end

    always_comb begin
      logic [RB:0]   r;
      logic [RB-1:0] rem;
      logic [QB-1:0] nq;
      r = '0;
      for (int k = 0; k < 3; k++) begin
        rem = dv_rem_in[s][k];
        nq  = dv_nq_in[s][k];
        for (int j = 0; j < prd_pkg::DivPerStage; j++) begin
          if (s * prd_pkg::DivPerStage + j < QB) begin
            r  = {rem, nq[QB-1]};
            nq = {nq[QB-2:0], 1'b0};
            if (r >= {1'b0, dv_len_in[s]}) begin
              r     = r - {1'b0, dv_len_in[s]};
              nq[0] = 1'b1;
            end
            rem = r[RB-1:0];
          end
        end
        dv_rem_d[s][k] = rem;
        dv_nq_d[s][k]  = nq;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[s] <= dv_rem_d[s];
      dv_nq_q[s]  <= dv_nq_d[s];
      dv_len_q[s] <= dv_len_in[s];
    end
  end

  // ---------------- rotation and rounding ----------------
  localparam int SideDiv = prd_pkg::SqStages + prd_pkg::DivStages + 4;
  localparam int SideOut = prd_pkg::SqStages + prd_pkg::DivStages + 7;

  logic signed [prd_pkg::DirBits-1:0] n_q   [3];
  logic signed [prd_pkg::MulBits-1:0] rm_q  [3][3];
  logic signed [prd_pkg::AccBits-1:0] acc_q [3];
  logic signed [prd_pkg::DirBits-1:0] dir_q [3];
  logic signed [prd_pkg::DirBits-1:0] dir_d [3];
  logic                               deg_q;

  always_ff @(posedge clk_i) begin
    logic [prd_pkg::DirBits-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = prd_pkg::DirBits'(dv_nq_q[prd_pkg::DivStages-1][k]);
      n_q[k] <= side_q[SideDiv].neg[k] ? signed'(-q) : signed'(q);
    end
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) rm_q[j][k] <= prd_pkg::coef(view_q[j], k) * n_q[k];
      acc_q[j] <= prd_pkg::AccBits'(rm_q[j][0]) + prd_pkg::AccBits'(rm_q[j][1])
                  + prd_pkg::AccBits'(rm_q[j][2]);
    end
  end

  always_comb begin
    logic [prd_pkg::AccBits-1:0] mag;
    logic [prd_pkg::AccBits-1:0] r;
    for (int j = 0; j < 3; j++) begin
      mag = acc_q[j][prd_pkg::AccBits-1] ? -acc_q[j] : acc_q[j];
      // half away from zero, then clamp to +-1.0
      r   = (mag + prd_pkg::AccBits'(1 << (prd_pkg::CoefFrac - 1))) >> prd_pkg::CoefFrac;
      if (r > prd_pkg::AccBits'(1 << prd_pkg::DirFrac))
        r = prd_pkg::AccBits'(1 << prd_pkg::DirFrac);
      if (acc_q[j][prd_pkg::AccBits-1]) dir_d[j] = signed'(-r[prd_pkg::DirBits-1:0]);
      else                              dir_d[j] = signed'(r[prd_pkg::DirBits-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    logic deg;
    deg = side_q[SideOut].deg | (width == '0) | (height == '0);
    for (int j = 0; j < 3; j++) dir_q[j] <= deg ? '0 : dir_d[j];
    deg_q <= deg;
  end

  assign result_valid_o = vld_q[prd_pkg::Latency-1];
  assign dir_x_o        = dir_q[0];
  assign dir_y_o        = dir_q[1];
  assign dir_z_o        = dir_q[2];
  assign degenerate_o   = deg_q;

endmodule
